// ===== src/awc_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the
// Ackermann wheel command unit. No dependencies.
package awc_pkg;

	typedef enum logic [1:0] {
		OP_TWIST     = 2'd0,
		OP_STEER_VEL = 2'd1,
		OP_STEER     = 2'd2,
		OP_VEL       = 2'd3
	} op_t;

	// register indexes on the configuration port
	localparam logic [1:0] REG_WHEEL_BASE   = 2'd0;
	localparam logic [1:0] REG_WHEEL_RADIUS = 2'd1;
	localparam logic [1:0] REG_WHEEL_TREAD  = 2'd2;

	localparam logic [13:0] BASE_RESET   = 14'd2950;
	localparam logic [10:0] RADIUS_RESET = 11'd341;
	localparam logic [12:0] TREAD_RESET  = 13'd1550;

	localparam logic signed [15:0] QUARTER_PI_Q14 = 16'sd12868;
	localparam logic [14:0] TAN_ONE_Q14 = 15'd16384;

	localparam logic [18:0] WRATE_MAX = 19'h3FFFF;
	localparam logic [18:0] WRATE_MIN = 19'h40000;

	// quotient bits of the two dividers
	localparam int WHEEL_QW = 19;
	localparam int TWIST_QW = 16;

	// CORDIC widths: rotation x/y, vectoring x/y, angle accumulator
	localparam int XW = 31;
	localparam int VW = 48;
	localparam int ZW = 32;
	localparam logic signed [XW-1:0] ROT_X0 = 31'sd268435456;

	typedef struct packed {
		logic valid;
		op_t  op;
		logic w_neg;
	} side_t;

	// floor(atan(2^-i) * 2^30)
	function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
		case (idx)
			5'd0:  return 32'sd843314856;
			5'd1:  return 32'sd497837829;
			5'd2:  return 32'sd263043836;
			5'd3:  return 32'sd133525158;
			5'd4:  return 32'sd67021686;
			5'd5:  return 32'sd33543515;
			5'd6:  return 32'sd16775850;
			5'd7:  return 32'sd8388437;
			5'd8:  return 32'sd4194282;
			5'd9:  return 32'sd2097149;
			5'd10: return 32'sd1048575;
			5'd11: return 32'sd524287;
			5'd12: return 32'sd262143;
			5'd13: return 32'sd131071;
			5'd14: return 32'sd65535;
			5'd15: return 32'sd32767;
			5'd16: return 32'sd16383;
			5'd17: return 32'sd8191;
			5'd18: return 32'sd4095;
			5'd19: return 32'sd2047;
			5'd20: return 32'sd1023;
			5'd21: return 32'sd511;
			5'd22: return 32'sd255;
			5'd23: return 32'sd127;
			5'd24: return 32'sd63;
			5'd25: return 32'sd31;
			5'd26: return 32'sd15;
			5'd27: return 32'sd7;
			5'd28: return 32'sd3;
			5'd29: return 32'sd1;
			default: return 32'sd0;
		endcase
	endfunction

endpackage

// ===== src/awc_dly.sv =====
// Fixed-length register delay line used to align pipeline branches.
// Depends on nothing.
module awc_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	if (N == 0) begin : g_thru
		assign dout = din;
	end else begin : g_line
		logic [W-1:0] line_q [N];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				for (int i = 0; i < N; i++) line_q[i] <= '0;
			end else begin
				line_q[0] <= din;
				for (int i = 1; i < N; i++) line_q[i] <= line_q[i-1];
			end
		end

		assign dout = line_q[N-1];
	end

endmodule

// ===== src/awc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow flag for quotients that need more than QW bits. No dependencies.
module awc_div #(
	parameter int NW = 25,
	parameter int DW = 11,
	parameter int QW = 19
) (
	input  logic          clk,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo,
	output logic          ovf
);

	localparam int TW = NW - QW;
	localparam int CW = (TW > DW) ? TW : DW;

	logic [CW-1:0] top_c;
	logic [CW-1:0] den_c;
	logic          ovf0;
	logic [DW-1:0] rem0;

	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] lo_s  [QW];
	logic [QW-1:0] quo_s [QW];
	logic [DW-1:0] den_s [QW];
	logic          ovf_s [QW];
	logic [DW:0]   nxt   [QW];

	function automatic logic [DW:0] div_step(input logic [DW-1:0] rem, input logic b,
			input logic [DW-1:0] d);
		logic [DW:0] t;
		logic [DW:0] diff;
		t = {rem, b};
		diff = t - {1'b0, d};
		if (t >= {1'b0, d}) return {1'b1, diff[DW-1:0]};
		return {1'b0, t[DW-1:0]};
	endfunction

	assign top_c = CW'(num[NW-1:QW]);
	assign den_c = CW'(den);
	assign ovf0  = (top_c >= den_c);
	assign rem0  = ovf0 ? '0 : DW'(top_c);

	always_comb begin
		nxt[0] = div_step(rem0, num[QW-1], den);
		for (int i = 1; i < QW; i++) nxt[i] = div_step(rem_s[i-1], lo_s[i-1][QW-1], den_s[i-1]);
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= nxt[0][DW-1:0];
		quo_s[0] <= {{(QW-1){1'b0}}, nxt[0][DW]};
		lo_s[0]  <= num[QW-1:0] << 1;
		den_s[0] <= den;
		ovf_s[0] <= ovf0;
		for (int i = 1; i < QW; i++) begin
			rem_s[i] <= nxt[i][DW-1:0];
			quo_s[i] <= {quo_s[i-1][QW-2:0], nxt[i][DW]};
			lo_s[i]  <= lo_s[i-1] << 1;
			den_s[i] <= den_s[i-1];
			ovf_s[i] <= ovf_s[i-1];
		end
	end

	assign quo = quo_s[QW-1];
	assign ovf = ovf_s[QW-1];

endmodule

// ===== src/awc_rot.sv =====
// Rotation-mode CORDIC pipeline: unscaled cosine and sine of a Q2.30 angle.
// Depends on awc_pkg for widths and the arctangent table.
module awc_rot import awc_pkg::*; #(
	parameter int STAGES = 16
) (
	input  logic                 clk,
	input  logic signed [ZW-1:0] z_in,
	output logic signed [XW-1:0] cos_out,
	output logic signed [XW-1:0] sin_out
);

	logic signed [XW-1:0] xi  [STAGES];
	logic signed [XW-1:0] yi  [STAGES];
	logic signed [ZW-1:0] zi  [STAGES];
	logic signed [XW-1:0] x_s [STAGES];
	logic signed [XW-1:0] y_s [STAGES];
	logic signed [ZW-1:0] z_s [STAGES];

	always_comb begin
		xi[0] = ROT_X0;
		yi[0] = '0;
		zi[0] = z_in;
		for (int i = 1; i < STAGES; i++) begin
			xi[i] = x_s[i-1];
			yi[i] = y_s[i-1];
			zi[i] = z_s[i-1];
		end
	end

	// rotate toward zero residual angle
	always_ff @(posedge clk) begin
		for (int i = 0; i < STAGES; i++) begin
			if (!zi[i][ZW-1]) begin
				x_s[i] <= xi[i] - (yi[i] >>> i);
				y_s[i] <= yi[i] + (xi[i] >>> i);
				z_s[i] <= zi[i] - atan_q30(5'(i));
			end else begin
				x_s[i] <= xi[i] + (yi[i] >>> i);
				y_s[i] <= yi[i] - (xi[i] >>> i);
				z_s[i] <= zi[i] + atan_q30(5'(i));
			end
		end
	end

	assign cos_out = x_s[STAGES-1];
	assign sin_out = y_s[STAGES-1];

endmodule

// ===== src/awc_vec.sv =====
// Vectoring-mode CORDIC pipeline: atan(y/x) rounded to Q2.14.
// Depends on awc_pkg for widths and the arctangent table.
module awc_vec import awc_pkg::*; #(
	parameter int STAGES = 16
) (
	input  logic                 clk,
	input  logic signed [VW-1:0] x_in,
	input  logic signed [VW-1:0] y_in,
	output logic signed [15:0]   angle
);

	logic signed [VW-1:0] x0_s;
	logic signed [VW-1:0] y0_s;
	logic                 zero0_s;

	logic signed [VW-1:0] xi   [STAGES];
	logic signed [VW-1:0] yi   [STAGES];
	logic signed [ZW-1:0] zi   [STAGES];
	logic                 zri  [STAGES];
	logic signed [VW-1:0] x_s  [STAGES];
	logic signed [VW-1:0] y_s  [STAGES];
	logic signed [ZW-1:0] z_s  [STAGES];
	logic                 zr_s [STAGES];

	logic signed [ZW:0]   z_rnd;
	logic signed [15:0]   angle_s;

	// fold a negative denominator into the right half plane
	always_ff @(posedge clk) begin
		zero0_s <= (y_in == '0);
		if (x_in[VW-1]) begin
			x0_s <= -x_in;
			y0_s <= -y_in;
		end else begin
			x0_s <= x_in;
			y0_s <= y_in;
		end
	end

	always_comb begin
		xi[0]  = x0_s;
		yi[0]  = y0_s;
		zi[0]  = '0;
		zri[0] = zero0_s;
		for (int i = 1; i < STAGES; i++) begin
			xi[i]  = x_s[i-1];
			yi[i]  = y_s[i-1];
			zi[i]  = z_s[i-1];
			zri[i] = zr_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < STAGES; i++) begin
			zr_s[i] <= zri[i];
			if (!yi[i][VW-1]) begin
				x_s[i] <= xi[i] + (yi[i] >>> i);
				y_s[i] <= yi[i] - (xi[i] >>> i);
				z_s[i] <= zi[i] + atan_q30(5'(i));
			end else begin
				x_s[i] <= xi[i] - (yi[i] >>> i);
				y_s[i] <= yi[i] + (xi[i] >>> i);
				z_s[i] <= zi[i] - atan_q30(5'(i));
			end
		end
	end

	assign z_rnd = (ZW+1)'(z_s[STAGES-1]) + 33'sd32768;

	always_ff @(posedge clk) begin
		angle_s <= zr_s[STAGES-1] ? 16'sd0 : z_rnd[31:16];
	end

	assign angle = angle_s;

endmodule

// ===== src/ackermann_wheel_command_unit.sv =====
// Ackermann wheel command unit: one command in per cycle, one result out.
// The depth from the start edge to the done strobe is set by the longer
// of the rotation CORDIC and the twist divider, followed by the vectoring
// CORDIC. Throughput: one command per cycle; busy stays low. Results
// cannot be held off by the receiver.
// Reset clears the valid bits and loads the geometry registers defaults.
module ackermann_wheel_command_unit import awc_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic signed [15:0] velocity,
	input  logic signed [15:0] yaw_rate,
	input  logic signed [15:0] steer_angle,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_addr,
	input  logic [13:0]        cfg_wdata,
	output logic               done,
	output logic signed [18:0] wheel_rate,
	output logic signed [15:0] right_angle,
	output logic signed [15:0] left_angle,
	output logic               wheel_valid,
	output logic               steer_valid
);

	localparam int LB = (CORDIC_STAGES > TWIST_QW) ? CORDIC_STAGES : TWIST_QW;

	logic [13:0] base_q;
	logic [10:0] radius_q;
	logic [12:0] tread_q;
	logic [10:0] reff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= BASE_RESET;
			radius_q <= RADIUS_RESET;
			tread_q  <= TREAD_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_WHEEL_BASE:   base_q   <= cfg_wdata;
				REG_WHEEL_RADIUS: radius_q <= cfg_wdata[10:0];
				REG_WHEEL_TREAD:  tread_q  <= cfg_wdata[12:0];
				default: ;
			endcase
		end
	end

	assign reff = (radius_q == '0) ? 11'd1 : radius_q;
	assign busy = 1'b0;

	// stage 1: capture the request
	logic               valid_s1;
	op_t                op_s1;
	logic signed [15:0] vel_s1, yaw_s1, steer_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= start & ~busy;
	end

	always_ff @(posedge clk) begin
		op_s1    <= op_t'(op);
		vel_s1   <= velocity;
		yaw_s1   <= yaw_rate;
		steer_s1 <= steer_angle;
	end

	logic [15:0]        vmag, wmag;
	logic [24:0]        numw;
	logic [23:0]        tden;
	logic [28:0]        tprod;
	logic signed [15:0] dcl;

	assign vmag  = vel_s1[15] ? 16'(-vel_s1) : 16'(vel_s1);
	assign wmag  = yaw_s1[15] ? 16'(-yaw_s1) : 16'(yaw_s1);
	assign numw  = 25'({9'd0, vmag} * 25'd1000) + 25'(reff[10:1]);
	assign tden  = (vmag <= 16'd2) ? 24'd1280 : 24'({8'd0, vmag} * 24'd500);
	assign tprod = 29'({13'd0, wmag} * {15'd0, base_q});

	always_comb begin
		if (steer_s1 > QUARTER_PI_Q14) dcl = QUARTER_PI_Q14;
		else if (steer_s1 < -QUARTER_PI_Q14) dcl = -QUARTER_PI_Q14;
		else dcl = steer_s1;
	end

	// stage 2
	logic               valid_s2, vneg_s2, wneg_s2;
	op_t                op_s2;
	logic [24:0]        numw_s2;
	logic [23:0]        tden_s2;
	logic [28:0]        tprod_s2;
	logic signed [15:0] dcl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		op_s2    <= op_s1;
		vneg_s2  <= vel_s1[15];
		wneg_s2  <= yaw_s1[15];
		numw_s2  <= numw;
		tden_s2  <= tden;
		tprod_s2 <= tprod;
		dcl_s2   <= dcl;
	end

	// stage 3: dividend with half the divisor added for rounding
	logic               valid_s3, vneg_s3, wneg_s3;
	op_t                op_s3;
	logic [24:0]        numw_s3;
	logic [23:0]        tden_s3;
	logic [37:0]        tnum_s3;
	logic signed [15:0] dcl_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		op_s3   <= op_s2;
		vneg_s3 <= vneg_s2;
		wneg_s3 <= wneg_s2;
		numw_s3 <= numw_s2;
		tden_s3 <= tden_s2;
		tnum_s3 <= {tprod_s2, 9'd0} + 38'(tden_s2[23:1]);
		dcl_s3  <= dcl_s2;
	end

	side_t side_s3;
	assign side_s3 = '{valid: valid_s3, op: op_s3, w_neg: wneg_s3};

	// wheel rate branch
	logic [WHEEL_QW-1:0] wq;
	logic                wovf, vneg_d;
	logic                wover_p, wover_n;
	logic [18:0]         wrate_s4;
	logic [18:0]         wrate_f;

	awc_div #(.NW(25), .DW(11), .QW(WHEEL_QW)) u_wdiv (
		.clk (clk), .num (numw_s3), .den (reff), .quo (wq), .ovf (wovf)
	);

	awc_dly #(.W(1), .N(WHEEL_QW)) u_vneg_dly (
		.clk (clk), .arst_n (arst_n), .din (vneg_s3), .dout (vneg_d)
	);

	assign wover_p = wovf | (wq > WRATE_MAX);
	assign wover_n = wovf | (wq > WRATE_MIN);

	always_ff @(posedge clk) begin
		if (vneg_d) wrate_s4 <= wover_n ? WRATE_MIN : (~wq + 19'd1);
		else wrate_s4 <= wover_p ? WRATE_MAX : wq;
	end

	awc_dly #(.W(19), .N(LB + CORDIC_STAGES - 15)) u_wrate_dly (
		.clk (clk), .arst_n (arst_n), .din (wrate_s4), .dout (wrate_f)
	);

	// steering branch: twist tangent or rotated steering angle
	logic [TWIST_QW-1:0]  tq, tq_d;
	logic                 tovf, tovf_d;
	logic signed [XW-1:0] rc, rs, rc_d, rs_d;
	side_t                side_d;

	awc_div #(.NW(38), .DW(24), .QW(TWIST_QW)) u_tdiv (
		.clk (clk), .num (tnum_s3), .den (tden_s3), .quo (tq), .ovf (tovf)
	);

	awc_rot #(.STAGES(CORDIC_STAGES)) u_rot (
		.clk (clk), .z_in ({dcl_s3, 16'd0}), .cos_out (rc), .sin_out (rs)
	);

	awc_dly #(.W(TWIST_QW + 1), .N(LB - TWIST_QW)) u_tq_dly (
		.clk (clk), .arst_n (arst_n), .din ({tovf, tq}), .dout ({tovf_d, tq_d})
	);

	awc_dly #(.W(2 * XW), .N(LB - CORDIC_STAGES)) u_rot_dly (
		.clk (clk), .arst_n (arst_n), .din ({rc, rs}), .dout ({rc_d, rs_d})
	);

	awc_dly #(.W($bits(side_t)), .N(LB)) u_side_dly (
		.clk (clk), .arst_n (arst_n), .din (side_s3), .dout (side_d)
	);

	// merge: clamp the tangent to one and pick sine/cosine parts
	logic [14:0]          tmag;
	side_t                side_s4, side_s5, side_s6, side_f;
	logic signed [XW-1:0] sin_s4, cos_s4;

	assign tmag = (tovf_d || tq_d > 16'(TAN_ONE_Q14)) ? TAN_ONE_Q14 : tq_d[14:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
			side_s5 <= '0;
			side_s6 <= '0;
		end else begin
			side_s4 <= side_d;
			side_s5 <= side_s4;
			side_s6 <= side_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (side_d.op == OP_TWIST) begin
			sin_s4 <= side_d.w_neg ? -XW'(tmag) : XW'(tmag);
			cos_s4 <= XW'(TAN_ONE_Q14);
		end else begin
			sin_s4 <= rs_d;
			cos_s4 <= rc_d;
		end
	end

	// products of the geometry with the sine/cosine parts
	logic signed [15:0]   b2s;
	logic signed [13:0]   ts;
	logic signed [VW-1:0] py_s5, pc_s5, pt_s5;
	logic signed [VW-1:0] y_s6, xr_s6, xl_s6;

	assign b2s = signed'({1'b0, base_q, 1'b0});
	assign ts  = signed'({1'b0, tread_q});

	always_ff @(posedge clk) begin
		py_s5 <= VW'(b2s * sin_s4);
		pc_s5 <= VW'(b2s * cos_s4);
		pt_s5 <= VW'(ts * sin_s4);
	end

	always_ff @(posedge clk) begin
		y_s6  <= py_s5;
		xr_s6 <= pc_s5 + pt_s5;
		xl_s6 <= pc_s5 - pt_s5;
	end

	logic signed [15:0] rang, lang;

	awc_vec #(.STAGES(CORDIC_STAGES)) u_vec_r (
		.clk (clk), .x_in (xr_s6), .y_in (y_s6), .angle (rang)
	);

	awc_vec #(.STAGES(CORDIC_STAGES)) u_vec_l (
		.clk (clk), .x_in (xl_s6), .y_in (y_s6), .angle (lang)
	);

	awc_dly #(.W($bits(side_t)), .N(CORDIC_STAGES + 2)) u_side_f_dly (
		.clk (clk), .arst_n (arst_n), .din (side_s6), .dout (side_f)
	);

	// result register: drop fields the command does not update
	logic               done_q;
	logic signed [18:0] wrate_q;
	logic signed [15:0] rang_q, lang_q;
	logic               wv_q, sv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= side_f.valid;
	end

	always_ff @(posedge clk) begin
		wrate_q <= (side_f.op == OP_STEER) ? 19'sd0 : signed'(wrate_f);
		rang_q  <= (side_f.op == OP_VEL) ? 16'sd0 : rang;
		lang_q  <= (side_f.op == OP_VEL) ? 16'sd0 : lang;
		wv_q    <= (side_f.op != OP_STEER);
		sv_q    <= (side_f.op != OP_VEL);
	end

	assign done        = done_q;
	assign wheel_rate  = wrate_q;
	assign right_angle = rang_q;
	assign left_angle  = lang_q;
	assign wheel_valid = wv_q;
	assign steer_valid = sv_q;

endmodule
